FILE: rtl/rsi_pkg.sv
// shared constants for the ray versus segment intersection block
`default_nettype none

package rsi_pkg;

  localparam int COORD_WIDTH_DEF      = 32;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int FRONT_STAGES         = 7;

endpackage

`default_nettype wire

FILE: rtl/ray_segment_intersect.sv
// top level: 2d ray versus line segment intersection with point and facing normal
//
//  channel  | ports                                    | handshake
//  ---------+------------------------------------------+------------------------------
//  item in  | origin_*, dir_*, seg_a*, seg_b*          | start_i high, busy_o low
//  item out | hit, point_x/y, normal_x/y               | done_o strobe, one cycle
//
//  one item a cycle; each result passes the front stages, the dividers and square
//  roots, then the output register; latency set by the longer of the point divider
//  and the normal divider then square root, one bit a stage
//  busy_o stays low; the pipeline has no stall, the result is a one-cycle strobe
//  reset clears the valid bits only
`default_nettype none

module ray_segment_intersect #(
  parameter int COORD_WIDTH      = rsi_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = rsi_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [COORD_WIDTH-1:0]        origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]        origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]        dir_x_i,
  input  logic signed [COORD_WIDTH-1:0]        dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]        seg_ax_i,
  input  logic signed [COORD_WIDTH-1:0]        seg_ay_i,
  input  logic signed [COORD_WIDTH-1:0]        seg_bx_i,
  input  logic signed [COORD_WIDTH-1:0]        seg_by_i,
  output logic                                 done_o,
  output logic                                 hit_o,
  output logic signed [COORD_WIDTH-1:0]        point_x_o,
  output logic signed [COORD_WIDTH-1:0]        point_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]   normal_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]   normal_y_o
);

  import rsi_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int F     = NORMAL_FRAC_BITS;
  localparam int EW    = W + 1;
  localparam int PW    = 2 * W + 2;
  localparam int SW    = PW + 1;
  localparam int MW    = 2 * W + 1;
  localparam int CHW   = (MW + 2) / 3;
  localparam int NPW   = 3 * CHW;
  localparam int CPW   = W + CHW;
  localparam int PPW   = 3 * W + 1;
  localparam int TOPW  = 3 * W + 2;
  localparam int BOTW  = 2 * W + 2;
  localparam int QPW   = W + 1;
  localparam int SQW   = 2 * W;
  localparam int LW    = 2 * W + 1;
  localparam int XW    = 2 * W + 2 * F + 2;
  localparam int QNW   = 2 * F + 3;
  localparam int ROOTW = F + 2;
  localparam int NW    = F + 2;
  localparam int TOT   = (W + 1 > 3 * F + 5) ? W + 1 : 3 * F + 5;
  localparam int DN    = TOT - ROOTW;
  localparam int LAT   = FRONT_STAGES + TOT + 1;
  localparam int NORM_ONE = 2 ** F;

  typedef struct packed {
    logic         hit;
    logic         neg_px;
    logic         neg_py;
    logic         neg_nx;
    logic         neg_ny;
    logic [W-1:0] ax;
    logic [W-1:0] ay;
  } side_t;

  // valid bits
  logic [FRONT_STAGES-1:0] vf_q;
  logic [TOT-1:0]          vd_q;
  logic                    done_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q   <= '0;
      vd_q   <= '0;
      done_q <= 1'b0;
    end else begin
      vf_q   <= {vf_q[FRONT_STAGES-2:0], start_i & ~busy_o};
      vd_q   <= {vd_q[TOT-2:0], vf_q[FRONT_STAGES-1]};
      done_q <= vd_q[TOT-1];
    end
  end

  // stage 1: differences
  logic signed [W-1:0]  dx1_q, dy1_q, ax1_q, ay1_q;
  logic signed [EW-1:0] ex1_q, ey1_q, apx1_q, apy1_q;

  always_ff @(posedge clk_i) begin
    dx1_q  <= dir_x_i;
    dy1_q  <= dir_y_i;
    ax1_q  <= seg_ax_i;
    ay1_q  <= seg_ay_i;
    ex1_q  <= EW'(seg_bx_i) - EW'(seg_ax_i);
    ey1_q  <= EW'(seg_by_i) - EW'(seg_ay_i);
    apx1_q <= EW'(seg_ax_i) - EW'(origin_x_i);
    apy1_q <= EW'(seg_ay_i) - EW'(origin_y_i);
  end

  // stage 2: cross products
  logic signed [PW-1:0] pden0_q, pden1_q, pnum0_q, pnum1_q, pside0_q, pside1_q;
  logic signed [EW-1:0] ex2_q, ey2_q;
  logic signed [W-1:0]  ax2_q, ay2_q;

  always_ff @(posedge clk_i) begin
    pden0_q  <= PW'(dy1_q) * PW'(ex1_q);
    pden1_q  <= PW'(dx1_q) * PW'(ey1_q);
    pnum0_q  <= PW'(dx1_q) * PW'(apy1_q);
    pnum1_q  <= PW'(dy1_q) * PW'(apx1_q);
    pside0_q <= PW'(apy1_q) * PW'(ex1_q);
    pside1_q <= PW'(apx1_q) * PW'(ey1_q);
    ex2_q    <= ex1_q;
    ey2_q    <= ey1_q;
    ax2_q    <= ax1_q;
    ay2_q    <= ay1_q;
  end

  // stage 3: denominator, numerator, side
  logic signed [PW-1:0] den3_q, num3_q;
  logic signed [SW-1:0] side3_q;
  logic signed [EW-1:0] ex3_q, ey3_q;
  logic signed [W-1:0]  ax3_q, ay3_q;

  always_ff @(posedge clk_i) begin
    den3_q  <= pden0_q - pden1_q;
    num3_q  <= pnum0_q - pnum1_q;
    side3_q <= SW'(pside0_q) - SW'(pside1_q);
    ex3_q   <= ex2_q;
    ey3_q   <= ey2_q;
    ax3_q   <= ax2_q;
    ay3_q   <= ay2_q;
  end

  // stage 4: magnitudes, signs, normal direction
  logic [PW-1:0]        den_abs, num_abs;
  logic [EW-1:0]        ex_abs, ey_abs;
  logic signed [EW-1:0] vx_d, vy_d;

  assign den_abs = den3_q[PW-1] ? PW'(-den3_q) : den3_q;
  assign num_abs = num3_q[PW-1] ? PW'(-num3_q) : num3_q;
  assign ex_abs  = ex3_q[EW-1] ? EW'(-ex3_q) : ex3_q;
  assign ey_abs  = ey3_q[EW-1] ? EW'(-ey3_q) : ey3_q;

  always_comb begin
    if (side3_q == '0) begin
      vx_d = ex3_q;
      vy_d = ey3_q;
    end else if (side3_q[SW-1]) begin
      vx_d = -ey3_q;
      vy_d = ex3_q;
    end else begin
      vx_d = ey3_q;
      vy_d = -ex3_q;
    end
  end

  logic [MW-1:0]        dena4_q, numa4_q;
  logic                 den_neg4_q, den_zero4_q, num_neg4_q, num_zero4_q;
  logic                 side_neg4_q, side_zero4_q, ex_neg4_q, ey_neg4_q;
  logic [W-1:0]         exa4_q, eya4_q;
  logic signed [EW-1:0] vx4_q, vy4_q;
  logic signed [W-1:0]  ax4_q, ay4_q;

  always_ff @(posedge clk_i) begin
    dena4_q      <= den_abs[MW-1:0];
    numa4_q      <= num_abs[MW-1:0];
    den_neg4_q   <= den3_q[PW-1];
    den_zero4_q  <= den3_q == '0;
    num_neg4_q   <= num3_q[PW-1];
    num_zero4_q  <= num3_q == '0;
    side_neg4_q  <= side3_q[SW-1];
    side_zero4_q <= side3_q == '0;
    ex_neg4_q    <= ex3_q[EW-1];
    ey_neg4_q    <= ey3_q[EW-1];
    exa4_q       <= ex_abs[W-1:0];
    eya4_q       <= ey_abs[W-1:0];
    vx4_q        <= vx_d;
    vy4_q        <= vy_d;
    ax4_q        <= ax3_q;
    ay4_q        <= ay3_q;
  end

  // stage 5: hit decision, partial products, squares
  logic [NPW-1:0] num_pad;
  logic [PW-1:0]  sqx_full, sqy_full;

  assign num_pad  = NPW'(numa4_q);
  assign sqx_full = PW'(vx4_q) * PW'(vx4_q);
  assign sqy_full = PW'(vy4_q) * PW'(vy4_q);

  logic [CPW-1:0]      cx5_q [3];
  logic [CPW-1:0]      cy5_q [3];
  logic [SQW-1:0]      sqx5_q, sqy5_q;
  logic [MW-1:0]       dena5_q;
  logic                hit5_q, neg_px5_q, neg_py5_q, neg_nx5_q, neg_ny5_q;
  logic signed [W-1:0] ax5_q, ay5_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      cx5_q[k] <= CPW'(exa4_q) * CPW'(num_pad[k*CHW +: CHW]);
      cy5_q[k] <= CPW'(eya4_q) * CPW'(num_pad[k*CHW +: CHW]);
    end
    sqx5_q    <= sqx_full[SQW-1:0];
    sqy5_q    <= sqy_full[SQW-1:0];
    dena5_q   <= dena4_q;
    hit5_q    <= !den_zero4_q
                 && (num_zero4_q || (num_neg4_q == den_neg4_q))
                 && (numa4_q <= dena4_q)
                 && (side_zero4_q || (side_neg4_q == den_neg4_q));
    neg_px5_q <= ex_neg4_q ^ num_neg4_q ^ den_neg4_q;
    neg_py5_q <= ey_neg4_q ^ num_neg4_q ^ den_neg4_q;
    neg_nx5_q <= vx4_q[EW-1];
    neg_ny5_q <= vy4_q[EW-1];
    ax5_q     <= ax4_q;
    ay5_q     <= ay4_q;
  end

  // stage 6: full products and squared length
  logic [PPW-1:0]      px6_q, py6_q;
  logic [LW-1:0]       l6_q;
  logic [SQW-1:0]      sqx6_q, sqy6_q;
  logic [MW-1:0]       dena6_q;
  logic                hit6_q, neg_px6_q, neg_py6_q, neg_nx6_q, neg_ny6_q;
  logic signed [W-1:0] ax6_q, ay6_q;

  always_ff @(posedge clk_i) begin
    px6_q     <= PPW'(cx5_q[0]) + (PPW'(cx5_q[1]) << CHW) + (PPW'(cx5_q[2]) << (2 * CHW));
    py6_q     <= PPW'(cy5_q[0]) + (PPW'(cy5_q[1]) << CHW) + (PPW'(cy5_q[2]) << (2 * CHW));
    l6_q      <= LW'(sqx5_q) + LW'(sqy5_q);
    sqx6_q    <= sqx5_q;
    sqy6_q    <= sqy5_q;
    dena6_q   <= dena5_q;
    hit6_q    <= hit5_q;
    neg_px6_q <= neg_px5_q;
    neg_py6_q <= neg_py5_q;
    neg_nx6_q <= neg_nx5_q;
    neg_ny6_q <= neg_ny5_q;
    ax6_q     <= ax5_q;
    ay6_q     <= ay5_q;
  end

  // stage 7: divider operands
  logic [TOPW-1:0] topx7_q, topy7_q;
  logic [BOTW-1:0] bot7_q;
  logic [XW-1:0]   xx7_q, xy7_q;
  logic [LW-1:0]   l7_q;
  side_t           side7_q;

  always_ff @(posedge clk_i) begin
    topx7_q <= TOPW'({px6_q, 1'b0}) + TOPW'(dena6_q);
    topy7_q <= TOPW'({py6_q, 1'b0}) + TOPW'(dena6_q);
    bot7_q  <= {dena6_q, 1'b0};
    xx7_q   <= {sqx6_q, {(2 * F + 2){1'b0}}};
    xy7_q   <= {sqy6_q, {(2 * F + 2){1'b0}}};
    l7_q    <= l6_q;
    side7_q <= '{hit: hit6_q, neg_px: neg_px6_q, neg_py: neg_py6_q,
                 neg_nx: neg_nx6_q, neg_ny: neg_ny6_q, ax: ax6_q, ay: ay6_q};
  end

  // dividers and square roots
  logic [QPW-1:0]   offx, offy;
  logic [QNW-1:0]   qnx, qny;
  logic [ROOTW-1:0] rootx, rooty;

  rsi_div #(.NUM_W(TOPW), .DEN_W(BOTW), .QUO_W(QPW), .DEPTH(TOT)) u_div_px (
    .clk_i (clk_i),
    .num_i (topx7_q),
    .den_i (bot7_q),
    .quo_o (offx)
  );

  rsi_div #(.NUM_W(TOPW), .DEN_W(BOTW), .QUO_W(QPW), .DEPTH(TOT)) u_div_py (
    .clk_i (clk_i),
    .num_i (topy7_q),
    .den_i (bot7_q),
    .quo_o (offy)
  );

  rsi_div #(.NUM_W(XW), .DEN_W(LW), .QUO_W(QNW), .DEPTH(DN)) u_div_nx (
    .clk_i (clk_i),
    .num_i (xx7_q),
    .den_i (l7_q),
    .quo_o (qnx)
  );

  rsi_div #(.NUM_W(XW), .DEN_W(LW), .QUO_W(QNW), .DEPTH(DN)) u_div_ny (
    .clk_i (clk_i),
    .num_i (xy7_q),
    .den_i (l7_q),
    .quo_o (qny)
  );

  rsi_sqrt #(.VAL_W(QNW), .ROOT_W(ROOTW)) u_sqrt_nx (
    .clk_i  (clk_i),
    .val_i  (qnx),
    .root_o (rootx)
  );

  rsi_sqrt #(.VAL_W(QNW), .ROOT_W(ROOTW)) u_sqrt_ny (
    .clk_i  (clk_i),
    .val_i  (qny),
    .root_o (rooty)
  );

  // side data alongside the dividers
  side_t dly_q [TOT];

  always_ff @(posedge clk_i) begin
    dly_q[0] <= side7_q;
    for (int i = 1; i < TOT; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  // final stage: offset, saturation, rounding of the normal
  side_t                fin;
  logic signed [W+1:0]  ptx_sum, pty_sum;
  logic signed [W+1:0]  offx_ext, offy_ext;
  logic signed [W-1:0]  ptx_sat, pty_sat;
  logic [ROOTW:0]       rx_inc, ry_inc;
  logic [NW-1:0]        nx_mag, ny_mag;
  logic signed [NW-1:0] nx_val, ny_val;

  assign fin      = dly_q[TOT-1];
  assign offx_ext = signed'({1'b0, offx});
  assign offy_ext = signed'({1'b0, offy});
  assign ptx_sum  = fin.neg_px ? (W+2)'(signed'(fin.ax)) - offx_ext
                               : (W+2)'(signed'(fin.ax)) + offx_ext;
  assign pty_sum  = fin.neg_py ? (W+2)'(signed'(fin.ay)) - offy_ext
                               : (W+2)'(signed'(fin.ay)) + offy_ext;

  always_comb begin
    if ((&ptx_sum[W+1:W-1]) || !(|ptx_sum[W+1:W-1])) begin
      ptx_sat = ptx_sum[W-1:0];
    end else begin
      ptx_sat = ptx_sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    if ((&pty_sum[W+1:W-1]) || !(|pty_sum[W+1:W-1])) begin
      pty_sat = pty_sum[W-1:0];
    end else begin
      pty_sat = pty_sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  end

  assign rx_inc = {1'b0, rootx} + (ROOTW+1)'(1);
  assign ry_inc = {1'b0, rooty} + (ROOTW+1)'(1);
  assign nx_mag = rx_inc[ROOTW:1];
  assign ny_mag = ry_inc[ROOTW:1];
  assign nx_val = fin.neg_nx ? -signed'(nx_mag) : signed'(nx_mag);
  assign ny_val = fin.neg_ny ? -signed'(ny_mag) : signed'(ny_mag);

  logic                 hit_q;
  logic signed [W-1:0]  point_x_q, point_y_q;
  logic signed [NW-1:0] normal_x_q, normal_y_q;

  always_ff @(posedge clk_i) begin
    hit_q      <= fin.hit;
    point_x_q  <= fin.hit ? ptx_sat : '0;
    point_y_q  <= fin.hit ? pty_sat : '0;
    normal_x_q <= fin.hit ? nx_val : '0;
    normal_y_q <= fin.hit ? ny_val : '0;
  end

  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign point_x_o  = point_x_q;
  assign point_y_o  = point_y_q;
  assign normal_x_o = normal_x_q;
  assign normal_y_o = normal_y_q;

  // checks
  ap_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("result missing after fixed latency");

  ap_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a started item");

  ap_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (point_x_o == '0 && point_y_o == '0
                            && normal_x_o == '0 && normal_y_o == '0))
    else $error("miss with nonzero fields");

  ap_normal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> ((normal_x_o != '0 || normal_y_o != '0)
                           && normal_x_o <= NORM_ONE && normal_x_o >= -NORM_ONE
                           && normal_y_o <= NORM_ONE && normal_y_o >= -NORM_ONE))
    else $error("normal out of range on a hit");

endmodule

`default_nettype wire

FILE: rtl/rsi_div.sv
// pipelined restoring divider, one quotient bit per stage, optional hold stages
`default_nettype none

module rsi_div #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int QUO_W = 4,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int REM_W = DEN_W + QUO_W;

  logic [REM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [DEPTH];

  for (genvar j = 0; j < DEPTH; j++) begin : g_stage
    if (j < QUO_W) begin : g_step
      logic [REM_W-1:0] rem_in;
      logic [REM_W-1:0] sub;
      logic [DEN_W-1:0] den_in;
      logic [QUO_W-1:0] quo_in;
      logic             ge;

      if (j == 0) begin : g_first
        assign rem_in = REM_W'(num_i);
        assign den_in = den_i;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[j-1];
        assign den_in = den_q[j-1];
        assign quo_in = quo_q[j-1];
      end

      assign sub = REM_W'(den_in) << (QUO_W - 1 - j);
      assign ge  = rem_in >= sub;

      always_ff @(posedge clk_i) begin
        rem_q[j] <= ge ? rem_in - sub : rem_in;
        den_q[j] <= den_in;
        quo_q[j] <= {quo_in[QUO_W-2:0], ge};
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        quo_q[j] <= quo_q[j-1];
      end
    end
  end

  assign quo_o = quo_q[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/rsi_sqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none

module rsi_sqrt #(
  parameter int VAL_W  = 8,
  parameter int ROOT_W = (VAL_W + 1) / 2
) (
  input  logic              clk_i,
  input  logic [VAL_W-1:0]  val_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int TW = 2 * ROOT_W + 1;

  logic [TW-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int B = ROOT_W - 1 - j;
    logic [TW-1:0]     rem_in;
    logic [TW-1:0]     trial;
    logic [ROOT_W-1:0] root_in;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in  = TW'(val_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign trial = TW'({root_in, 2'b01}) << (2 * B);
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= ge ? rem_in - trial : rem_in;
      root_q[j] <= {root_in[ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// testbench for ray_segment_intersect: driven items, exact prediction and result checking
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

  localparam int CW       = rsi_pkg::COORD_WIDTH_DEF;
  localparam int NF       = rsi_pkg::NORMAL_FRAC_BITS_DEF;
  localparam int N_RANDOM = 2000;
  localparam int IDLE_MAX = 3000;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic signed [CW-1:0] ox, oy, dx, dy, ax, ay, bx, by;
  } ray_seg_t;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] px, py;
    logic [NF+1:0] nx, ny;
  } crossing_t;

  class crossing_board;
    crossing_t pending_q[$];
    int        errors;

    function wide_t mag(wide_t v);
      return (v < 0) ? -v : v;
    endfunction

    function int sgn(wide_t v);
      return (v == 0) ? 0 : ((v < 0) ? -1 : 1);
    endfunction

    // a + e*num/den, rounded half away from zero, saturated
    function logic [CW-1:0] place(wide_t a, wide_t e, wide_t num, wide_t den);
      wide_t p, q, v, lim;
      logic  neg;
      p   = e * num;
      neg = (p < 0) != (den < 0);
      q   = (2 * mag(p) + mag(den)) / (2 * mag(den));
      v   = neg ? a - q : a + q;
      lim = wide_t'(1) <<< (CW - 1);
      if (v > lim - 1) v = lim - 1;
      if (v < -lim) v = -lim;
      return v[CW-1:0];
    endfunction

    // v * 2^NF / sqrt(len2), rounded half away from zero
    function logic [NF+1:0] unit(wide_t v, wide_t len2);
      wide_t rhs, k;
      int    lo, hi, mid, n;
      rhs = mag(v) * mag(v) * (wide_t'(1) <<< (2 * NF + 2));
      lo  = 0;
      hi  = 1 << NF;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        k   = 2 * mid - 1;
        if (k * k * len2 <= rhs) lo = mid;
        else hi = mid - 1;
      end
      n = (v < 0) ? -lo : lo;
      return n[NF+1:0];
    endfunction

    function void note(ray_seg_t r);
      crossing_t c;
      wide_t     ex, ey, apx, apy, den, num, side, vx, vy;
      int        sd, sn, ss;
      c   = '0;
      ex  = wide_t'(r.bx) - wide_t'(r.ax);
      ey  = wide_t'(r.by) - wide_t'(r.ay);
      apx = wide_t'(r.ax) - wide_t'(r.ox);
      apy = wide_t'(r.ay) - wide_t'(r.oy);
      den  = wide_t'(r.dy) * ex - wide_t'(r.dx) * ey;
      num  = wide_t'(r.dx) * apy - wide_t'(r.dy) * apx;
      side = apy * ex - apx * ey;
      sd = sgn(den);
      sn = sgn(num);
      ss = sgn(side);
      if (sd != 0 && (sn == 0 || sn == sd) && mag(num) <= mag(den) &&
          (ss == 0 || ss == sd)) begin
        c.hit = 1'b1;
        c.px  = place(wide_t'(r.ax), ex, num, den);
        c.py  = place(wide_t'(r.ay), ey, num, den);
        if (ss == 0) begin
          vx = ex; vy = ey;
        end else if (ss < 0) begin
          vx = -ey; vy = ex;
        end else begin
          vx = ey; vy = -ex;
        end
        c.nx = unit(vx, vx * vx + vy * vy);
        c.ny = unit(vy, vx * vx + vy * vy);
      end
      pending_q.push_back(c);
    endfunction

    function void check(crossing_t got);
      crossing_t exp_c;
      if (pending_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      exp_c = pending_q.pop_front();
      if (got.hit !== exp_c.hit) begin
        $error("hit: expected %0d, got %0d", exp_c.hit, got.hit); errors++;
      end
      if (got.px !== exp_c.px) begin
        $error("point_x: expected %h, got %h", exp_c.px, got.px); errors++;
      end
      if (got.py !== exp_c.py) begin
        $error("point_y: expected %h, got %h", exp_c.py, got.py); errors++;
      end
      if (got.nx !== exp_c.nx) begin
        $error("normal_x: expected %h, got %h", exp_c.nx, got.nx); errors++;
      end
      if (got.ny !== exp_c.ny) begin
        $error("normal_y: expected %h, got %h", exp_c.ny, got.ny); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start_i, busy_o, done_o, hit_o;
  logic signed [CW-1:0] origin_x_i, origin_y_i, dir_x_i, dir_y_i;
  logic signed [CW-1:0] seg_ax_i, seg_ay_i, seg_bx_i, seg_by_i;
  logic signed [CW-1:0] point_x_o, point_y_o;
  logic signed [NF+1:0] normal_x_o, normal_y_o;

  ray_segment_intersect DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .origin_x_i(origin_x_i), .origin_y_i(origin_y_i),
    .dir_x_i(dir_x_i), .dir_y_i(dir_y_i),
    .seg_ax_i(seg_ax_i), .seg_ay_i(seg_ay_i),
    .seg_bx_i(seg_bx_i), .seg_by_i(seg_by_i),
    .done_o(done_o), .hit_o(hit_o),
    .point_x_o(point_x_o), .point_y_o(point_y_o),
    .normal_x_o(normal_x_o), .normal_y_o(normal_y_o)
  );

  crossing_board board = new();
  int            idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        board.note({origin_x_i, origin_y_i, dir_x_i, dir_y_i,
                    seg_ax_i, seg_ay_i, seg_bx_i, seg_by_i});
      end
      if (done_o) begin
        board.check({hit_o, point_x_o, point_y_o, normal_x_o, normal_y_o});
      end
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_MAX) begin
        $display("** ray_segment_intersect: FAILED **");
        $finish;
      end
    end
  end

  task automatic send(ray_seg_t r);
    {origin_x_i, origin_y_i, dir_x_i, dir_y_i,
     seg_ax_i, seg_ay_i, seg_bx_i, seg_by_i} <= r;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic pause(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] near();
    return $signed(CW'($urandom_range(0, 2097152))) - 32'sd1048576;
  endfunction

  function automatic ray_seg_t random_item();
    ray_seg_t r;
    int       kind;
    logic signed [CW-1:0] qx, qy;
    kind = $urandom_range(0, 99);
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (kind < 75) begin
      r.ax = near(); r.ay = near(); r.bx = near(); r.by = near();
      r.ox = near(); r.oy = near();
      if (kind < 60) begin
        // aim at a point on the segment
        qx = r.ax + (r.bx - r.ax) / $signed($urandom_range(1, 8));
        qy = r.ay + (r.by - r.ay) / $signed($urandom_range(1, 8));
        r.dx = (qx - r.ox) * $signed($urandom_range(1, 4));
        r.dy = (qy - r.oy) * $signed($urandom_range(1, 4));
        if (kind < 8) begin
          r.dx = -r.dx; r.dy = -r.dy;
        end
      end else begin
        // parallel to the segment
        r.dx = (r.bx - r.ax) * 2;
        r.dy = (r.by - r.ay) * 2;
      end
    end
    return r;
  endfunction

  localparam logic signed [CW-1:0] MAXC = 32'sh7fffffff;
  localparam logic signed [CW-1:0] MINC = 32'sh80000000;
  localparam logic signed [CW-1:0] ONE  = 32'sh00010000;

  initial begin
    ray_seg_t dir_items[$];
    int       sent, burst;
    rst_ni = 1'b0;
    start_i = 1'b0;
    {origin_x_i, origin_y_i, dir_x_i, dir_y_i} = '0;
    {seg_ax_i, seg_ay_i, seg_bx_i, seg_by_i} = '0;
    idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain hit, segment ends, origin on segment, ray pointing away, degenerate, parallel and extreme cases
    dir_items.push_back({32'sd0, 32'sd0, ONE, 32'sd0, 2*ONE, -ONE, 2*ONE, ONE});
    dir_items.push_back({32'sd0, 32'sd0, ONE, 32'sd0, 2*ONE, 32'sd0, 2*ONE, ONE});
    dir_items.push_back({32'sd0, 32'sd0, ONE, 32'sd0, 2*ONE, -ONE, 2*ONE, 32'sd0});
    dir_items.push_back({32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, -ONE, 32'sd0, ONE});
    dir_items.push_back({32'sd0, 32'sd0, -ONE, 32'sd0, 2*ONE, -ONE, 2*ONE, ONE});
    dir_items.push_back({32'sd0, 32'sd0, ONE, 32'sd0, 2*ONE, ONE, 2*ONE, ONE});
    dir_items.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 2*ONE, -ONE, 2*ONE, ONE});
    dir_items.push_back({32'sd0, 32'sd0, ONE, ONE, ONE, 32'sd0, 2*ONE, ONE});
    dir_items.push_back({32'sd0, 32'sd0, ONE, 32'sd0, ONE, 32'sd0, 3*ONE, 32'sd0});
    dir_items.push_back({32'sd0, 32'sd0, ONE, 32'sd0, 2*ONE, 2*ONE, 2*ONE, 3*ONE});
    dir_items.push_back({32'sd0, 32'sd0, ONE, ONE, 3*ONE, 32'sd0, 32'sd0, 3*ONE});
    dir_items.push_back({32'sd0, 32'sd0, 32'sd3, 32'sd0, 32'sd1, -32'sd1, 32'sd2, 32'sd2});
    dir_items.push_back({MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MAXC});
    dir_items.push_back({MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC});
    dir_items.push_back({MINC, 32'sd0, MAXC, 32'sd0, MAXC, MINC, MAXC, MAXC});
    dir_items.push_back({MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC});
    dir_items.push_back({MINC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC});
    dir_items.push_back({32'sd0, 32'sd0, 32'sd1, 32'sd0, MAXC, MINC, MAXC, MAXC});
    dir_items.push_back({32'sd0, 32'sd0, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC});
    foreach (dir_items[i]) send(dir_items[i]);

    // hold off until the pipeline has drained
    pause(1);
    wait (board.pending_q.size() == 0);
    @(posedge clk_i);

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send(random_item());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
    pause(1);

    wait (board.pending_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("** ray_segment_intersect: PASSED **");
    else
      $display("** ray_segment_intersect: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

FILE: ray_segment_intersect.f
rtl/rsi_pkg.sv
rtl/rsi_div.sv
rtl/rsi_sqrt.sv
rtl/ray_segment_intersect.sv
bench/tb_top.sv
